// ===== rtl/cld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_pkg
// Shared types and codes for the console line discipline: result kinds,
// control characters, sequencer states and the result record.
// ----------------------------------------------------------------------------
package cld_pkg;

   // Result kinds
   localparam logic [2:0] KIND_NONE      = 3'd0;
   localparam logic [2:0] KIND_ECHO      = 3'd1;
   localparam logic [2:0] KIND_ERASE     = 3'd2;
   localparam logic [2:0] KIND_INTERRUPT = 3'd3;
   localparam logic [2:0] KIND_READ_BYTE = 3'd4;
   localparam logic [2:0] KIND_EMPTY     = 3'd5;
   localparam logic [2:0] KIND_EOF       = 3'd6;

   // Control characters
   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_INTR = 8'h03;
   localparam logic [7:0] CH_EOF  = 8'h04;
   localparam logic [7:0] CH_BS   = 8'h08;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_KILL = 8'h15;
   localparam logic [7:0] CH_DEL  = 8'h7F;

   // Request modes
   localparam logic MODE_CHAR = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } cld_state_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] out_char;
      logic [7:0] erase_count;
      logic       wake_readers;
      logic       line_end;
   } cld_result_type;

endpackage

// ===== rtl/cld_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cld_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_core
// Line editing engine: ring positions, line store and the read sequencer.
// ----------------------------------------------------------------------------
module cld_core #(
   parameter int BUFFER_DEPTH = 128
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_mode,
   input  logic [7:0]              req_char,
   input  logic                    req_started,
   input  logic                    out_room,
   output logic                    res_valid,
   output cld_pkg::cld_result_type res
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int PW = $clog2(2 * BUFFER_DEPTH);
   localparam int CW = (PW > 8) ? PW : 8;

   localparam logic [PW-1:0] POS_LAST   = PW'(2 * BUFFER_DEPTH - 1);
   localparam logic [PW-1:0] POS_DEPTH  = PW'(BUFFER_DEPTH);
   localparam logic [PW-1:0] POS_ALMOST = PW'(BUFFER_DEPTH - 1);
   localparam logic [PW:0]   POS_MOD    = (PW + 1)'(2 * BUFFER_DEPTH);

   function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
      return (p == POS_LAST) ? '0 : p + PW'(1);
   endfunction

   function automatic logic [PW-1:0] pos_dec(input logic [PW-1:0] p);
      return (p == '0) ? POS_LAST : p - PW'(1);
   endfunction

   function automatic logic [PW-1:0] pos_diff(input logic [PW-1:0] a,
                                              input logic [PW-1:0] b);
      logic [PW:0] wide;
      wide = {1'b0, a} + POS_MOD - {1'b0, b};
      return (a >= b) ? (a - b) : wide[PW-1:0];
   endfunction

   function automatic logic [AW-1:0] pos_slot(input logic [PW-1:0] p);
      logic [PW-1:0] s;
      s = (p >= POS_DEPTH) ? (p - POS_DEPTH) : p;
      return s[AW-1:0];
   endfunction

   cld_pkg::cld_state_type state_ff, state_in;
   logic [PW-1:0] read_ff, read_in;
   logic [PW-1:0] commit_ff, commit_in;
   logic [PW-1:0] edit_ff, edit_in;
   logic          started_ff, started_in;

   logic          accept;
   logic          wr_en;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [7:0]    rd_data;
   logic [PW-1:0] used;
   logic [PW-1:0] pending;
   logic [CW-1:0] pending_ext;
   logic [7:0]    stored;

   cld_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_slot(edit_ff)),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (pos_slot(read_ff)),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= cld_pkg::ST_IDLE;
         read_ff   <= '0;
         commit_ff <= '0;
         edit_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         read_ff   <= read_in;
         commit_ff <= commit_in;
         edit_ff   <= edit_in;
      end
      started_ff <= started_in;
   end

   always_comb begin
      state_in    = state_ff;
      read_in     = read_ff;
      commit_in   = commit_ff;
      edit_in     = edit_ff;
      started_in  = started_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      res_valid   = 1'b0;
      res         = '0;
      used        = pos_diff(edit_ff, read_ff);
      pending     = pos_diff(edit_ff, commit_ff);
      pending_ext = CW'(pending);
      stored      = (req_char == cld_pkg::CH_CR) ? cld_pkg::CH_LF : req_char;
      wr_data     = stored;
      req_ready   = (state_ff == cld_pkg::ST_IDLE) && out_room;
      accept      = req_valid && req_ready;

      case (state_ff)
         cld_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_mode == cld_pkg::MODE_READ) begin
                  if (read_ff == commit_ff) begin
                     res_valid = 1'b1;
                     res.kind  = cld_pkg::KIND_EMPTY;
                  end else begin
                     // fetch the next committed byte, decide next cycle
                     rd_en      = 1'b1;
                     started_in = req_started;
                     state_in   = cld_pkg::ST_READ;
                  end
               end else begin
                  res_valid = 1'b1;
                  if (req_char == cld_pkg::CH_NUL) begin
                     res.kind = cld_pkg::KIND_NONE;
                  end else if (req_char == cld_pkg::CH_BS ||
                               req_char == cld_pkg::CH_DEL) begin
                     if (edit_ff != commit_ff) begin
                        edit_in         = pos_dec(edit_ff);
                        res.kind        = cld_pkg::KIND_ERASE;
                        res.erase_count = 8'd1;
                     end
                  end else if (req_char == cld_pkg::CH_KILL) begin
                     if (pending != '0) begin
                        edit_in         = commit_ff;
                        res.kind        = cld_pkg::KIND_ERASE;
                        res.erase_count = (pending_ext > CW'(255)) ? 8'd255
                                                                  : pending_ext[7:0];
                     end
                  end else if (req_char == cld_pkg::CH_INTR) begin
                     res.kind = cld_pkg::KIND_INTERRUPT;
                  end else if (used < POS_DEPTH) begin
                     wr_en        = 1'b1;
                     edit_in      = pos_inc(edit_ff);
                     res.kind     = cld_pkg::KIND_ECHO;
                     res.out_char = stored;
                     if (stored == cld_pkg::CH_LF || stored == cld_pkg::CH_EOF ||
                         used == POS_ALMOST) begin
                        commit_in        = pos_inc(edit_ff);
                        res.wake_readers = 1'b1;
                     end
                  end
               end
            end
         end
         cld_pkg::ST_READ: begin
            res_valid = 1'b1;
            state_in  = cld_pkg::ST_IDLE;
            if (rd_data == cld_pkg::CH_EOF) begin
               res.kind = cld_pkg::KIND_EOF;
               if (!started_ff) begin
                  read_in = pos_inc(read_ff);
               end
            end else begin
               read_in      = pos_inc(read_ff);
               res.kind     = cld_pkg::KIND_READ_BYTE;
               res.out_char = rd_data;
               res.line_end = (rd_data == cld_pkg::CH_LF);
            end
         end
         default: begin
            state_in = cld_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/console_line_discipline.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_line_discipline
// Canonical console line editor over a ring of BUFFER_DEPTH bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: each item is a received character (tuser 0) or a request
//   to read one byte (tuser 1). Every item yields exactly one rsp item.
//   rsp channel: tuser carries the result kind, tlast flags a returned
//   newline, tdata carries the echoed or read byte, the erase count and the
//   wake flag for readers.
//   Timing: a received character or a read that finds nothing committed
//   is finished when it is accepted, and its result is on rsp in the next
//   cycle. A read that finds a committed byte first fetches it through the
//   registered read of the line store memory and is decided in ST_READ.
//   One item is worked at a time.
//   Reset: ring positions return to zero; the line store is not cleared,
//   since no entry is read before it is written. No clearing pass runs.
//   Stall: the result waits in the rsp output register while rsp_tready is
//   low; req_tready stays low until that register drains or is taken in
//   the same cycle.
// ----------------------------------------------------------------------------
module console_line_discipline #(
   parameter int BUFFER_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] char_in, [8] read_started, [15:9] zero
   input  logic        req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_char, [15:8] erase_count,
                                    // [16] wake_readers, [23:17] zero
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast    // line_end
);

   logic                    out_room;
   logic                    res_valid;
   cld_pkg::cld_result_type res;

   // output register: holds one finished result while the receiver stalls
   logic                    rsp_valid_ff, rsp_valid_in;
   cld_pkg::cld_result_type rsp_ff, rsp_in;

   // the engine may finish an item whenever the output register is free
   // or is being taken in this cycle
   assign out_room = !rsp_valid_ff || rsp_tready;

   cld_core #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_mode    (req_tuser),
      .req_char    (req_tdata[7:0]),
      .req_started (req_tdata[8]),
      .out_room    (out_room),
      .res_valid   (res_valid),
      .res         (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      // drop the held result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      // load a new result; the engine only finishes when there is room
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.line_end;
   assign rsp_tdata  = {7'd0, rsp_ff.wake_readers, rsp_ff.erase_count, rsp_ff.out_char};

endmodule

// ===== tb/sv/cld_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_checker
// Watches both streams of the console line discipline, predicts one result
// per accepted item from its own copy of the ring and positions, and
// compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module cld_checker #(
   parameter int BUFFER_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] char_in, [8] read_started, [15:9] zero
   input  logic        req_tuser,   // [0] mode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [7:0] out_char, [15:8] erase_count,
                                    // [16] wake_readers, [23:17] zero
   input  logic [2:0]  rsp_tuser,   // [2:0] kind
   input  logic        rsp_tlast,   // line_end
   output int          pending,
   output int          errors
);

   localparam int unsigned POS_MOD = 2 * BUFFER_DEPTH;

   logic [7:0]                  ring [BUFFER_DEPTH];
   int unsigned                 rd_pos;
   int unsigned                 commit_pos;
   int unsigned                 edit_pos;
   cld_pkg::cld_result_type     due_results[$];
   int                          mismatches = 0;

   initial begin
      foreach (ring[i]) ring[i] = 8'h00;
   end

   function automatic int unsigned wrap_add(int unsigned a, int unsigned k);
      return (a + k) % POS_MOD;
   endfunction

   function automatic int unsigned span(int unsigned a, int unsigned b);
      return (a + POS_MOD - b) % POS_MOD;
   endfunction

   // Edit the line or serve a read, and return the result it yields
   function automatic cld_pkg::cld_result_type edit_or_read(logic mode, logic [7:0] ch,
                                                            logic started);
      cld_pkg::cld_result_type res;
      logic [7:0]              c;
      int unsigned             n;
      res = '0;
      c   = ch;
      if (mode == cld_pkg::MODE_READ) begin
         if (rd_pos == commit_pos) begin
            res.kind = cld_pkg::KIND_EMPTY;
         end else if (ring[rd_pos % BUFFER_DEPTH] == cld_pkg::CH_EOF) begin
            res.kind = cld_pkg::KIND_EOF;
            if (!started) rd_pos = wrap_add(rd_pos, 1);
         end else begin
            res.kind     = cld_pkg::KIND_READ_BYTE;
            res.out_char = ring[rd_pos % BUFFER_DEPTH];
            res.line_end = (res.out_char == cld_pkg::CH_LF);
            rd_pos       = wrap_add(rd_pos, 1);
         end
      end else if (c == cld_pkg::CH_NUL) begin
         res.kind = cld_pkg::KIND_NONE;
      end else if (c == cld_pkg::CH_BS || c == cld_pkg::CH_DEL) begin
         if (edit_pos != commit_pos) begin
            edit_pos        = wrap_add(edit_pos, POS_MOD - 1);
            res.kind        = cld_pkg::KIND_ERASE;
            res.erase_count = 8'd1;
         end
      end else if (c == cld_pkg::CH_KILL) begin
         n = span(edit_pos, commit_pos);
         if (n != 0) begin
            edit_pos        = commit_pos;
            res.kind        = cld_pkg::KIND_ERASE;
            res.erase_count = (n > 255) ? 8'd255 : 8'(n);
         end
      end else if (c == cld_pkg::CH_INTR) begin
         res.kind = cld_pkg::KIND_INTERRUPT;
      end else if (span(edit_pos, rd_pos) < BUFFER_DEPTH) begin
         if (c == cld_pkg::CH_CR) c = cld_pkg::CH_LF;
         ring[edit_pos % BUFFER_DEPTH] = c;
         edit_pos     = wrap_add(edit_pos, 1);
         res.kind     = cld_pkg::KIND_ECHO;
         res.out_char = c;
         if (c == cld_pkg::CH_LF || c == cld_pkg::CH_EOF ||
             span(edit_pos, rd_pos) == BUFFER_DEPTH) begin
            commit_pos       = edit_pos;
            res.wake_readers = 1'b1;
         end
      end
      return res;
   endfunction

   task automatic flag_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      cld_pkg::cld_result_type want;
      cld_pkg::cld_result_type got;
      if (reset) begin
         rd_pos     = 0;
         commit_pos = 0;
         edit_pos   = 0;
         due_results.delete();
      end else begin
         // check the result first: it always belongs to an older item
         if (rsp_tvalid && rsp_tready) begin
            got.kind         = rsp_tuser;
            got.out_char     = rsp_tdata[7:0];
            got.erase_count  = rsp_tdata[15:8];
            got.wake_readers = rsp_tdata[16];
            got.line_end     = rsp_tlast;
            if (due_results.size() == 0) begin
               flag_mismatch($sformatf({"unexpected result kind=%0d char=%02h",
                                        " erase=%0d wake=%b end=%b"},
                                       got.kind, got.out_char, got.erase_count,
                                       got.wake_readers, got.line_end));
            end else begin
               want = due_results.pop_front();
               if (got.kind !== want.kind || got.out_char !== want.out_char ||
                   got.erase_count !== want.erase_count ||
                   got.wake_readers !== want.wake_readers ||
                   got.line_end !== want.line_end) begin
                  flag_mismatch($sformatf({"expected kind=%0d char=%02h erase=%0d",
                                           " wake=%b end=%b,",
                                           " actual kind=%0d char=%02h erase=%0d",
                                           " wake=%b end=%b"},
                                          want.kind, want.out_char, want.erase_count,
                                          want.wake_readers, want.line_end,
                                          got.kind, got.out_char, got.erase_count,
                                          got.wake_readers, got.line_end));
               end
            end
         end
         if (req_tvalid && req_tready)
            due_results.push_back(edit_or_read(req_tuser, req_tdata[7:0], req_tdata[8]));
      end
      pending <= due_results.size();
      errors  <= mismatches;
   end

endmodule

// ===== tb/sv/console_line_discipline_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_line_discipline_tb
// Drives typed characters and read requests into the console line
// discipline: a directed pass over the control characters, erase, commit
// and end-of-file cases, then random typing sessions, read calls and noise
// under bursty sending and a stalling receiver. The checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module console_line_discipline_tb;

   localparam int BUFFER_DEPTH = 128;
   localparam int ITEM_TARGET  = 2000;
   localparam int CYCLE_LIMIT  = 400000;

   // receiver stall styles, each held for a random stretch of cycles
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_PERIODIC,
      RX_SPARSE
   } rx_style_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [7:0] char_in, [8] read_started, [15:9] zero
   logic        req_tuser  = 1'b0; // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [7:0] out_char, [15:8] erase_count,
                                   // [16] wake_readers, [23:17] zero
   logic [2:0]  rsp_tuser;         // [2:0] kind
   logic        rsp_tlast;         // line_end

   int           pending_results;
   int           mismatch_total;
   int           cycle_count = 0;
   int           items_sent  = 0;
   int           burst_left  = 0;
   int           stall_left  = 0;
   rx_style_type rx_style    = RX_OPEN;

   always #2 clock = ~clock;

   console_line_discipline #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   cld_checker #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) checker_i (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .pending   (pending_results),
      .errors    (mismatch_total)
   );

   // Count cycles; the watchdog below ends a hung run
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // Receiver: switch among stall styles, with fully open stretches too
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_left <= $urandom_range(20, 200);
            rx_style   <= rx_style_type'($urandom_range(0, 3));
         end else begin
            stall_left <= stall_left - 1;
         end
         case (rx_style)
            RX_OPEN:     rsp_tready <= 1'b1;
            RX_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: rsp_tready <= (cycle_count % 4 == 0);
            default:     rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Present one item and hold it until accepted. Bursts keep tvalid high
   // from item to item; a new burst may open with a random gap.
   task automatic send_item(logic mode, logic [7:0] ch, logic started);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {7'd0, started, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // a dropped NUL does not count toward the item budget
      if (!(mode == cld_pkg::MODE_CHAR && ch == cld_pkg::CH_NUL)) items_sent++;
   endtask

   // Typed character: the read_started bit is ignored, so randomize it
   task automatic send_char(logic [7:0] ch);
      send_item(cld_pkg::MODE_CHAR, ch, 1'($urandom_range(0, 1)));
   endtask

   // Read request: char_in is ignored, so randomize it
   task automatic send_read(logic started);
      send_item(cld_pkg::MODE_READ, 8'($urandom_range(0, 255)), started);
   endtask

   // Hold the sender off until every predicted result has been taken
   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // Type one line with random content, occasional edits and a random end
   task automatic type_line(int len);
      int         pick;
      logic [7:0] ch;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 15);
         if (pick == 0)
            ch = ($urandom_range(0, 1) == 1) ? cld_pkg::CH_BS : cld_pkg::CH_DEL;
         else if (pick == 1)
            ch = 8'($urandom_range(0, 255));
         else
            ch = 8'($urandom_range(8'h20, 8'h7e));
         send_char(ch);
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3: send_char(cld_pkg::CH_CR);
         4, 5:       send_char(cld_pkg::CH_LF);
         6:          send_char(cld_pkg::CH_EOF);
         7:          send_char(cld_pkg::CH_KILL);
         8:          send_char(cld_pkg::CH_INTR);
         default:    ;
      endcase
   endtask

   // One read call: the first byte with read_started low, the rest high, now and then a random bit
   task automatic read_call(int len);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 15) == 0)
            send_read(1'($urandom_range(0, 1)));
         else
            send_read(i > 0);
      end
   endtask

   initial begin
      bit drained_mid;
      drained_mid = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: nothing to read, ignored and refused controls
      send_read(1'b1);
      send_char(cld_pkg::CH_NUL);
      send_char(cld_pkg::CH_BS);
      send_char(cld_pkg::CH_DEL);
      send_char(cld_pkg::CH_KILL);
      send_char(cld_pkg::CH_INTR);
      // echo at the byte extremes, single erase, then kill the rest
      send_char(8'h61);
      send_char(8'hff);
      send_char(8'h80);
      send_char(cld_pkg::CH_BS);
      send_char(cld_pkg::CH_KILL);
      // CR becomes LF and commits; read the line back and run dry
      send_char(8'h78);
      send_char(cld_pkg::CH_CR);
      send_read(1'b0);
      send_read(1'b1);
      send_read(1'b1);
      // Ctrl-D commits; a started read leaves it, a fresh read consumes it
      send_char(cld_pkg::CH_EOF);
      send_read(1'b1);
      send_read(1'b0);
      send_read(1'b0);
      // bare LF line
      send_char(cld_pkg::CH_LF);
      send_read(1'b0);
      drain_results();

      // Random: mostly typing sessions and read calls, some noise
      while (items_sent < ITEM_TARGET) begin
         if (!drained_mid && items_sent >= ITEM_TARGET / 2) begin
            drain_results();
            drained_mid = 1'b1;
         end
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8:
               type_line($urandom_range(0, 12));
            9:
               // long line: may fill the ring, or end in a big kill
               type_line($urandom_range(100, 140));
            10, 11, 12, 13, 14, 15, 16:
               read_call($urandom_range(1, 24));
            default:
               repeat ($urandom_range(1, 8))
                  send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
         endcase
      end

      // Let every result come back, then allow the block to settle
      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_total == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
